// ===== design/lcgc_pkg.sv =====
// Types, constants and tables for the character LCD glyph cache writer.
// Holds the microcode table, the glyph ROM and the item structs.
// No dependencies.
package lcgc_pkg;

   typedef logic [3:0] step_type;

   localparam step_type STEP_IDLE   = 4'd0;
   localparam step_type STEP_DECIDE = 4'd1;
   localparam step_type STEP_LOAD   = 4'd2;
   localparam step_type STEP_ROW0   = 4'd3;
   localparam step_type STEP_ROW7   = 4'd10;
   localparam step_type STEP_CURSOR = 4'd11;
   localparam step_type STEP_DATA   = 4'd12;

   localparam logic [7:0] CHAR_SPACE    = 8'h20;
   localparam logic [7:0] CMD_SET_CGRAM = 8'h40;
   localparam logic [7:0] CMD_SET_DDRAM = 8'h80;
   localparam logic [7:0] DDRAM_LINE2   = 8'h40;
   localparam int         GLYPH_COUNT   = 11;

   typedef enum logic [1:0] {
      SEL_LOAD_CMD,
      SEL_ROW,
      SEL_CURSOR,
      SEL_DATA
   } out_sel_type;

   typedef enum logic [1:0] {
      JUMP_NEXT,
      JUMP_ACCEPT,
      JUMP_DECIDE
   } jump_type;

   typedef struct packed {
      logic        emit;
      out_sel_type sel;
      logic        last;
      jump_type    jump;
      step_type    target;
      logic [2:0]  row;
   } ctrl_word_type;

   typedef struct packed {
      logic accept;
      logic skip;
      logic miss;
      logic out_free;
   } seq_status_type;

   typedef struct packed {
      logic       mode;
      logic [7:0] char_code;
      logic [7:0] start_column;
      logic [7:0] position;
   } req_item_type;

   typedef struct packed {
      logic       reg_select;
      logic [7:0] byte_value;
      logic       last_of_run;
   } rsp_item_type;

   typedef struct packed {
      logic       found;
      logic [3:0] idx;
   } glyph_match_type;

   function automatic ctrl_word_type ucode_word(input step_type step);
      ctrl_word_type w;
      w = '{emit: 1'b0, sel: SEL_ROW, last: 1'b0, jump: JUMP_NEXT,
            target: STEP_IDLE, row: 3'd0};
      case (step) inside
         STEP_IDLE: begin
            w.jump   = JUMP_ACCEPT;
            w.target = STEP_DECIDE;
         end
         STEP_DECIDE: begin
            w.jump   = JUMP_DECIDE;
            w.target = STEP_LOAD;
         end
         STEP_LOAD: begin
            w.emit   = 1'b1;
            w.sel    = SEL_LOAD_CMD;
            w.target = STEP_ROW0;
         end
         [STEP_ROW0:STEP_ROW7]: begin
            w.emit   = 1'b1;
            w.sel    = SEL_ROW;
            w.row    = 3'(step - STEP_ROW0);
            w.target = step + 4'd1;
         end
         STEP_CURSOR: begin
            w.emit   = 1'b1;
            w.sel    = SEL_CURSOR;
            w.target = STEP_DATA;
         end
         STEP_DATA: begin
            w.emit   = 1'b1;
            w.sel    = SEL_DATA;
            w.last   = 1'b1;
            w.target = STEP_IDLE;
         end
         default: begin
            w.target = STEP_IDLE;
         end
      endcase
      return w;
   endfunction

   function automatic glyph_match_type glyph_lookup(input logic [7:0] c);
      glyph_match_type m;
      m.found = 1'b1;
      m.idx   = 4'd0;
      if (c >= "0" && c <= "9") begin
         m.idx = 4'(c - "0");
      end else if (c == "*") begin
         m.idx = 4'(GLYPH_COUNT - 1);
      end else begin
         m.found = 1'b0;
      end
      return m;
   endfunction

   function automatic logic [7:0] glyph_row(input logic [3:0] idx, input logic [2:0] row);
      logic [63:0] rows;
      unique case (idx)
         4'd0:    rows = 64'h000E_1113_1519_110E;
         4'd1:    rows = 64'h000E_0404_0404_0604;
         4'd2:    rows = 64'h001F_0204_0810_110E;
         4'd3:    rows = 64'h000E_1110_0C10_110E;
         4'd4:    rows = 64'h0008_081F_090A_0C08;
         4'd5:    rows = 64'h000E_1110_100F_011F;
         4'd6:    rows = 64'h000E_1111_0F01_020C;
         4'd7:    rows = 64'h0002_0202_0408_101F;
         4'd8:    rows = 64'h000E_1111_0E11_110E;
         4'd9:    rows = 64'h0006_0810_1E11_110E;
         4'd10:   rows = 64'h0000_0A04_1F04_0A00;
         default: rows = 64'h0;
      endcase
      return rows[8*(7 - int'(row)) +: 8];
   endfunction

endpackage

// ===== design/char_lcd_glyph_cache_writer.sv =====
// Top level of the character LCD glyph cache writer.
// Depends on lcgc_pkg, lcgc_sequencer and lcgc_datapath.
//
// Usage:
//   req channel: one item per character (mode, char_code, start_column,
//   position). req_stall is low only while the sequencer waits for an item.
//   rsp channel: controller byte writes (reg_select, byte_value), with
//   last_of_run set on the final write of an item.
//   A column past the panel width gives no write; a space or any other
//   non-glyph character gives a cursor command and a space; a glyph hit gives
//   a cursor command and a slot number; a miss first writes a CGRAM address
//   and eight pattern rows, then the cursor command and slot number.
// Timing:
//   One item at a time, set by the microcode step counter: accept, decide,
//   then one step per byte write. The first write is registered in the
//   step after decide. A stalled rsp item holds; the sequencer waits on
//   that step, so an item takes longer while the receiver stalls.
// Reset:
//   Synchronous reset clears the slot tags, the round-robin pointer, the
//   step counter and the rsp valid flag.
module char_lcd_glyph_cache_writer #(
   parameter int NUM_COLS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  lcgc_pkg::req_item_type req_item,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output lcgc_pkg::rsp_item_type rsp_item
);
   import lcgc_pkg::*;

   ctrl_word_type  ctrl;
   seq_status_type status;
   logic           idle;
   logic           accept;

   assign req_stall = !idle;
   assign accept    = req_valid && idle;

   lcgc_sequencer u_sequencer (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctrl   (ctrl),
      .idle   (idle)
   );

   lcgc_datapath #(
      .NUM_COLS (NUM_COLS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .req_item  (req_item),
      .ctrl      (ctrl),
      .rsp_stall (rsp_stall),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> req_stall)
      else $error("input open right after an item was taken");

   a_skip_returns_idle: assert property (@(posedge clock) disable iff (reset)
      (ctrl.jump == JUMP_DECIDE) && status.skip |=> !req_stall)
      else $error("past-end item did not return to idle");

   a_emit_keeps_busy: assert property (@(posedge clock) disable iff (reset)
      (ctrl.jump == JUMP_DECIDE) && !status.skip |=> req_stall)
      else $error("item with writes released the input early");

   a_last_is_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.last_of_run |-> rsp_item.reg_select)
      else $error("final write of an item is not a data byte");

endmodule

// ===== design/lcgc_sequencer.sv =====
// Microcode sequencer: step counter, control word table and jump logic.
// Depends on lcgc_pkg.
module lcgc_sequencer (
   input  logic                    clock,
   input  logic                    reset,
   input  lcgc_pkg::seq_status_type status,
   output lcgc_pkg::ctrl_word_type  ctrl,
   output logic                    idle
);
   import lcgc_pkg::*;

   step_type pc_ff;
   step_type pc_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= STEP_IDLE;
      end else begin
         pc_ff <= pc_in;
      end
   end

   always_comb begin
      ctrl  = ucode_word(pc_ff);
      idle  = (ctrl.jump == JUMP_ACCEPT);
      pc_in = pc_ff;
      unique case (ctrl.jump)
         JUMP_ACCEPT: begin
            if (status.accept) pc_in = ctrl.target;
         end
         JUMP_DECIDE: begin
            if (status.skip) begin
               pc_in = STEP_IDLE;
            end else if (status.miss) begin
               pc_in = ctrl.target;
            end else begin
               pc_in = STEP_CURSOR;
            end
         end
         JUMP_NEXT: begin
            if (!ctrl.emit || status.out_free) pc_in = ctrl.target;
         end
         default: pc_in = STEP_IDLE;
      endcase
   end

endmodule

// ===== design/lcgc_datapath.sv =====
// Datapath: item register, slot tag cache, glyph ROM and result register.
// Depends on lcgc_pkg; driven by the control word of lcgc_sequencer.
module lcgc_datapath #(
   parameter int NUM_COLS = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    accept,
   input  lcgc_pkg::req_item_type  req_item,
   input  lcgc_pkg::ctrl_word_type ctrl,
   input  logic                    rsp_stall,
   output lcgc_pkg::seq_status_type status,
   output logic                    rsp_valid,
   output lcgc_pkg::rsp_item_type  rsp_item
);
   import lcgc_pkg::*;

   localparam logic [3:0] LastCol = 4'(NUM_COLS - 1);

   req_item_type    item_ff;
   logic [7:0]      tags_ff [8];
   logic [2:0]      next_slot_ff;
   logic [2:0]      slot_ff;
   logic [3:0]      gidx_ff;
   logic [7:0]      cmd_ff;
   logic [7:0]      data_ff;
   logic            rsp_valid_ff;
   rsp_item_type    rsp_item_ff;

   logic [7:0]      user;
   logic [3:0]      phys;
   logic [7:0]      cmd;
   logic            skip;
   glyph_match_type match;
   logic [7:0]      hit_vec;
   logic            hit_any;
   logic [2:0]      hit_slot;
   logic [2:0]      pass_slot;
   logic            hit;
   logic [2:0]      slot_pick;
   logic            miss;
   logic            decide;
   logic            out_free;
   rsp_item_type    out_item;

   always_comb begin
      user      = item_ff.start_column + item_ff.position;
      skip      = (user >= 8'(NUM_COLS));
      phys      = LastCol - user[3:0];
      cmd       = CMD_SET_DDRAM | (phys[3] ? DDRAM_LINE2 : 8'h00) | {5'b0, phys[2:0]};
      match     = glyph_lookup(item_ff.char_code);
      hit_any   = 1'b0;
      hit_slot  = 3'd0;
      for (int s = 7; s >= 0; s--) begin
         hit_vec[s] = (tags_ff[s] == item_ff.char_code);
         if (hit_vec[s]) begin
            hit_any  = 1'b1;
            hit_slot = 3'(s);
         end
      end
      pass_slot = item_ff.position[2:0];
      if (item_ff.mode) begin
         hit       = hit_vec[pass_slot];
         slot_pick = pass_slot;
      end else begin
         hit       = hit_any;
         slot_pick = hit_any ? hit_slot : next_slot_ff;
      end
      miss      = match.found && !hit;
      decide    = (ctrl.jump == JUMP_DECIDE);
      out_free  = !rsp_valid_ff || !rsp_stall;
      status    = '{accept: accept, skip: skip, miss: miss, out_free: out_free};
   end

   always_comb begin
      out_item.last_of_run = ctrl.last;
      case (ctrl.sel)
         SEL_LOAD_CMD: begin
            out_item.reg_select = 1'b0;
            out_item.byte_value = CMD_SET_CGRAM | {2'b00, slot_ff, 3'b000};
         end
         SEL_ROW: begin
            out_item.reg_select = 1'b1;
            out_item.byte_value = glyph_row(gidx_ff, ctrl.row);
         end
         SEL_CURSOR: begin
            out_item.reg_select = 1'b0;
            out_item.byte_value = cmd_ff;
         end
         default: begin
            out_item.reg_select = 1'b1;
            out_item.byte_value = data_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (accept) item_ff <= req_item;
      if (decide) begin
         slot_ff <= slot_pick;
         gidx_ff <= match.idx;
         cmd_ff  <= cmd;
         data_ff <= match.found ? {5'b0, slot_pick} : CHAR_SPACE;
      end
      if (ctrl.emit && out_free) rsp_item_ff <= out_item;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < 8; s++) tags_ff[s] <= 8'h00;
         next_slot_ff <= 3'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (decide && !skip && miss) begin
            tags_ff[slot_pick] <= item_ff.char_code;
            if (!item_ff.mode) next_slot_ff <= next_slot_ff + 3'd1;
         end
         if (ctrl.emit && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule

// ===== verif/lcgc_write_checker.sv =====
// Checker for the character LCD glyph cache writer: watches both channels,
// predicts the controller byte writes of each accepted character and compares.
// Depends on lcgc_pkg for the item types and controller command constants.
`timescale 1ns / 1ps
module lcgc_write_checker #(
   parameter int NUM_COLS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_stall,
   input  lcgc_pkg::req_item_type req_item,
   input  logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  lcgc_pkg::rsp_item_type rsp_item,
   output int                     failures,
   output int                     outstanding
);
   import lcgc_pkg::*;

   localparam logic RS_COMMAND = 1'b0;
   localparam logic RS_DATA    = 1'b1;

   logic [7:0]   slot_char [8];
   logic [2:0]   rr_slot;
   rsp_item_type lcd_writes [$];
   rsp_item_type want;
   int           fail_count;

   function automatic logic is_glyph(input logic [7:0] c);
      return (c >= "0" && c <= "9") || c == "*";
   endfunction

   function automatic logic [63:0] glyph_pattern(input logic [7:0] c);
      case (c)
         "0":     return 64'h000E11131519110E;
         "1":     return 64'h000E040404040604;
         "2":     return 64'h001F02040810110E;
         "3":     return 64'h000E11100C10110E;
         "4":     return 64'h0008081F090A0C08;
         "5":     return 64'h000E1110100F011F;
         "6":     return 64'h000E11110F01020C;
         "7":     return 64'h000202020408101F;
         "8":     return 64'h000E11110E11110E;
         "9":     return 64'h000608101E11110E;
         "*":     return 64'h00000A041F040A00;
         default: return 64'h0;
      endcase
   endfunction

   task automatic push_write(input logic rs, input logic [7:0] b, input logic last);
      rsp_item_type w;
      w.reg_select  = rs;
      w.byte_value  = b;
      w.last_of_run = last;
      lcd_writes.push_back(w);
   endtask

   task automatic predict_writes(input req_item_type it);
      logic [7:0]  user;
      logic [7:0]  phys;
      logic [7:0]  cursor;
      logic [7:0]  shown;
      logic [2:0]  slot;
      logic        hit;
      logic        reload;
      logic [63:0] rows;
      user = it.start_column + it.position;
      if (user >= NUM_COLS) begin
         return;
      end
      phys   = 8'(NUM_COLS - 1) - user;
      shown  = CHAR_SPACE;
      reload = 1'b0;
      if (is_glyph(it.char_code)) begin
         if (it.mode) begin
            slot   = it.position[2:0];
            reload = slot_char[slot] != it.char_code;
         end else begin
            hit  = 1'b0;
            slot = rr_slot;
            for (int s = 7; s >= 0; s--) begin
               if (slot_char[s] == it.char_code) begin
                  slot = 3'(s);
                  hit  = 1'b1;
               end
            end
            if (!hit) begin
               reload  = 1'b1;
               rr_slot = rr_slot + 3'd1;
            end
         end
         shown = {5'b0, slot};
         if (reload) begin
            slot_char[slot] = it.char_code;
            push_write(RS_COMMAND, CMD_SET_CGRAM | {2'b0, slot, 3'b0}, 1'b0);
            rows = glyph_pattern(it.char_code);
            for (int r = 7; r >= 0; r--) begin
               push_write(RS_DATA, rows[8*r +: 8], 1'b0);
            end
         end
      end
      if (phys < 8) begin
         cursor = CMD_SET_DDRAM | phys;
      end else begin
         cursor = CMD_SET_DDRAM | DDRAM_LINE2 | (phys - 8'd8);
      end
      push_write(RS_COMMAND, cursor, 1'b0);
      push_write(RS_DATA, shown, 1'b1);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < 8; s++) begin
            slot_char[s] = 8'h00;
         end
         rr_slot    = 3'd0;
         fail_count = 0;
         lcd_writes.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (lcd_writes.size() == 0) begin
               $error("unexpected write: reg_select %0d byte_value %h last_of_run %0d",
                      rsp_item.reg_select, rsp_item.byte_value, rsp_item.last_of_run);
               fail_count++;
            end else begin
               want = lcd_writes.pop_front();
               if (rsp_item.reg_select !== want.reg_select) begin
                  $error("reg_select: expected %0d, got %0d",
                         want.reg_select, rsp_item.reg_select);
                  fail_count++;
               end
               if (rsp_item.byte_value !== want.byte_value) begin
                  $error("byte_value: expected %h, got %h",
                         want.byte_value, rsp_item.byte_value);
                  fail_count++;
               end
               if (rsp_item.last_of_run !== want.last_of_run) begin
                  $error("last_of_run: expected %0d, got %0d",
                         want.last_of_run, rsp_item.last_of_run);
                  fail_count++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            predict_writes(req_item);
         end
      end
      failures    <= fail_count;
      outstanding <= lcd_writes.size();
   end

endmodule

// ===== verif/char_lcd_glyph_cache_writer_test.sv =====
// Testbench top for the character LCD glyph cache writer: drives characters
// with random idling on both channels and gives the verdict.
// Depends on lcgc_pkg, the block and lcgc_write_checker.
`timescale 1ns / 1ps
module char_lcd_glyph_cache_writer_test;
   import lcgc_pkg::*;

   localparam int   NUM_COLS      = 16;
   localparam int   RANDOM_ITEMS  = 124;
   localparam int   CYCLE_LIMIT   = 200000;
   localparam int   DRAIN_CYCLES  = 40;
   localparam logic MODE_NORMAL   = 1'b0;
   localparam logic MODE_PASSWORD = 1'b1;

   logic         clock;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_item_type req_item  = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_item_type rsp_item;

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int cycles        = 0;
   int sent_items    = 0;
   int failures;
   int outstanding;

   char_lcd_glyph_cache_writer #(.NUM_COLS(NUM_COLS)) uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

   lcgc_write_checker #(.NUM_COLS(NUM_COLS)) write_check (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_item    (req_item),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_item    (rsp_item),
      .failures    (failures),
      .outstanding (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_stall <= $urandom_range(99) < recv_idle_pct;
      cycles    <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   task automatic send_char(input logic mode, input logic [7:0] c,
                            input logic [7:0] col, input logic [7:0] pos);
      req_item  <= '{mode: mode, char_code: c, start_column: col, position: pos};
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sent_items++;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
   endtask

   function automatic logic [7:0] pick_char();
      int r;
      int k;
      r = $urandom_range(99);
      k = $urandom_range(10);
      if (r < 60) begin
         return (k == 10) ? 8'("*") : 8'("0") + 8'(k);
      end else if (r < 75) begin
         return CHAR_SPACE;
      end
      return 8'($urandom_range(255));
   endfunction

   task automatic send_string();
      logic       mode;
      logic [7:0] base;
      logic [7:0] start;
      int         len;
      mode  = 1'($urandom_range(1));
      len   = $urandom_range(16, 1);
      base  = ($urandom_range(99) < 20) ? 8'($urandom_range(255)) : 8'd0;
      start = ($urandom_range(99) < 85) ? 8'($urandom_range(15)) : 8'($urandom_range(255));
      if ($urandom_range(99) < 10) begin
         send_char(1'($urandom_range(1)), 8'($urandom_range(255)),
                   8'($urandom_range(255)), 8'($urandom_range(255)));
      end else begin
         for (int p = 0; p < len; p++) begin
            send_char(mode, pick_char(), start - base, base + 8'(p));
         end
      end
   endtask

   initial begin
      send_idle_pct = 34;
      recv_idle_pct = 63;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      send_char(MODE_NORMAL, CHAR_SPACE, 8'd0, 8'd0);
      for (int k = 0; k < 11; k++) begin
         send_char(MODE_NORMAL, (k == 10) ? 8'("*") : 8'("0") + 8'(k), 8'(k), 8'd0);
      end
      send_char(MODE_NORMAL, "3", 8'd15, 8'd0);
      send_char(MODE_NORMAL, "*", 8'd8, 8'd0);
      send_char(MODE_NORMAL, "A", 8'd7, 8'd0);
      send_char(MODE_NORMAL, 8'hFF, 8'd0, 8'd15);
      send_char(MODE_NORMAL, 8'h00, 8'd15, 8'd0);
      send_char(MODE_NORMAL, "5", 8'd16, 8'd0);
      send_char(MODE_NORMAL, "7", 8'd200, 8'd100);
      send_char(MODE_NORMAL, "1", 8'd255, 8'd255);
      send_char(MODE_NORMAL, "9", 8'd255, 8'd1);
      send_char(MODE_PASSWORD, "5", 8'd0, 8'd3);
      send_char(MODE_PASSWORD, "5", 8'd0, 8'd11);
      send_char(MODE_PASSWORD, "*", 8'd1, 8'd255);
      send_char(MODE_PASSWORD, "*", 8'd255, 8'd255);
      send_char(MODE_PASSWORD, CHAR_SPACE, 8'd4, 8'd4);

      sent_items = 0;
      while (sent_items < RANDOM_ITEMS / 3) send_string();
      send_idle_pct = 63;
      recv_idle_pct = 34;
      while (sent_items < 2 * RANDOM_ITEMS / 3) send_string();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      while (sent_items < RANDOM_ITEMS) send_string();
      req_valid <= 1'b0;

      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

// ===== char_lcd_glyph_cache_writer.f =====
design/lcgc_pkg.sv
design/lcgc_sequencer.sv
design/lcgc_datapath.sv
design/char_lcd_glyph_cache_writer.sv
verif/lcgc_write_checker.sv
verif/char_lcd_glyph_cache_writer_test.sv
